/* rtl/core/rgbhsv_pkg.sv */
// Package for the RGB to HSV pixel converter.
// Shared types and constants; no dependencies.
package rgbhsv_pkg;

  localparam int ChanW = 8;
  localparam int HueW  = 9;
  localparam int NumW  = 16;   // dividend width for both restoring dividers
  localparam int QuoW  = 8;    // quotient bits, one per divider stage

  localparam logic [HueW-1:0] Hue120 = 9'd120;
  localparam logic [HueW-1:0] Hue240 = 9'd240;
  localparam logic [HueW-1:0] Hue360 = 9'd360;

  typedef enum logic [1:0] {
    SECT_RED   = 2'd0,
    SECT_GREEN = 2'd1,
    SECT_BLUE  = 2'd2
  } sector_e;

  // Payload carried through the divider stages
  typedef struct packed {
    logic [NumW-1:0]  sat_num;   // partial remainder of 255*delta
    logic [QuoW-1:0]  sat_quo;
    logic [NumW-1:0]  hue_num;   // partial remainder of 60*|diff|
    logic [QuoW-1:0]  hue_quo;
    logic [ChanW-1:0] vmax;      // saturation divisor and value output
    logic [ChanW-1:0] delta;     // hue divisor
    sector_e          sector;
    logic             neg;       // hue difference below zero
    logic             gray;      // delta zero
  } div_stage_t;

endpackage

/* rtl/core/rgb_to_hsv_pixel_top.sv */
// Pipeline from input transaction to result: front end, scaling,
// 8 restoring divider stages at one quotient bit each, hue assembly.
// Throughput: one pixel per cycle; the whole pipeline holds while the output
// stage is full and not taken. rst_ni clears all valid bits asynchronously.
// Top level of the RGB to HSV pixel converter.
// Depends on rgbhsv_pkg.
module rgb_to_hsv_pixel_top import rgbhsv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // hue_degrees[8:0], saturation_code[16:9],
                                      // value_code[24:17], zero[31:25]
);

  localparam int NStg = QuoW + 1;

  logic en;

  // ---------------- stage 1: max, min, sector, difference -----------------
  logic [ChanW-1:0] red, green, blue, mx, mn, dif_a, dif_b;
  sector_e          sect_d;

  assign red   = s_axis_tdata[7:0];
  assign green = s_axis_tdata[15:8];
  assign blue  = s_axis_tdata[23:16];

  always_comb begin
    mx = (red > green) ? red : green;
    mx = (mx > blue) ? mx : blue;
    mn = (red < green) ? red : green;
    mn = (mn < blue) ? mn : blue;
    if (red == mx) begin
      sect_d = SECT_RED;
      dif_a  = green;
      dif_b  = blue;
    end else if (green == mx) begin
      sect_d = SECT_GREEN;
      dif_a  = blue;
      dif_b  = red;
    end else begin
      sect_d = SECT_BLUE;
      dif_a  = red;
      dif_b  = green;
    end
  end

  logic             s1_valid_q;
  logic [ChanW-1:0] s1_vmax_q, s1_delta_q, s1_adiff_q;
  sector_e          s1_sector_q;
  logic             s1_neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_vmax_q   <= mx;
      s1_delta_q  <= mx - mn;
      s1_sector_q <= sect_d;
      s1_neg_q    <= dif_a < dif_b;
      s1_adiff_q  <= (dif_a < dif_b) ? (dif_b - dif_a) : (dif_a - dif_b);
    end
  end

  // ---------------- stage 2: scale the dividends --------------------------
  logic       vld_q [NStg];
  div_stage_t stg_q [NStg];
  div_stage_t stg0_d;

  always_comb begin
    stg0_d.sat_num = {s1_delta_q, 8'd0} - NumW'(s1_delta_q);            // 255*delta
    stg0_d.hue_num = (NumW'(s1_adiff_q) << 6) - (NumW'(s1_adiff_q) << 2); // 60*|diff|
    stg0_d.sat_quo = '0;
    stg0_d.hue_quo = '0;
    stg0_d.vmax    = s1_vmax_q;
    stg0_d.delta   = s1_delta_q;
    stg0_d.sector  = s1_sector_q;
    stg0_d.neg     = s1_neg_q;
    stg0_d.gray    = (s1_delta_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      stg_q[0] <= stg0_d;
    end
  end

  // ---------------- stages 3..10: restoring divide, MSB first -------------
  for (genvar k = 0; k < QuoW; k++) begin : g_div
    localparam int Sh = QuoW - 1 - k;
    div_stage_t       nxt;
    logic [NumW-1:0]  sden, hden;

    always_comb begin
      nxt  = stg_q[k];
      sden = NumW'(stg_q[k].vmax) << Sh;
      hden = NumW'(stg_q[k].delta) << Sh;
      if (stg_q[k].sat_num >= sden) begin
        nxt.sat_num     = stg_q[k].sat_num - sden;
        nxt.sat_quo[Sh] = 1'b1;
      end
      if (stg_q[k].hue_num >= hden) begin
        nxt.hue_num     = stg_q[k].hue_num - hden;
        nxt.hue_quo[Sh] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        stg_q[k+1] <= nxt;
      end
    end
  end

  // ---------------- stage 11: hue assembly, output register ---------------
  div_stage_t      last;
  logic [6:0]      hq, hceil;
  logic [HueW-1:0] hue_d, base;
  logic [ChanW-1:0] sat_d;

  always_comb begin
    last  = stg_q[NStg-1];
    hq    = last.hue_quo[6:0];            // at most 60
    hceil = hq + 7'(last.hue_num != '0);
    case (last.sector)
      SECT_RED:   base = last.neg ? Hue360 : '0;
      SECT_GREEN: base = Hue120;
      SECT_BLUE:  base = Hue240;
      default:    base = '0;
    endcase
    hue_d = last.neg ? (base - HueW'(hceil)) : (base + HueW'(hq));
    sat_d = last.sat_quo;
    if (last.gray) begin
      hue_d = '0;
      sat_d = '0;
    end
  end

  logic             out_valid_q;
  logic [HueW-1:0]  out_hue_q;
  logic [ChanW-1:0] out_sat_q, out_val_q;

  assign en = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld_q[NStg-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_hue_q <= hue_d;
      out_sat_q <= sat_d;
      out_val_q <= last.vmax;
    end
  end

  assign s_axis_tready = en;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_val_q, out_sat_q, out_hue_q};

endmodule

/* rtl/core/rgbhsv_checker.sv */
// Port-level assertions for the RGB to HSV converter, bound to the top level.
// Depends on rgb_to_hsv_pixel_top.
module rgbhsv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output transaction changed while stalled");

  // input only backs up when output is full and blocked
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[8:0] < 9'd360 && m_axis_tdata[31:25] == 7'd0)
    else $error("hue out of range or pad bits set");

  // zero saturation only for gray pixels, whose hue is zero
  a_gray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[16:9] == 8'd0 |-> m_axis_tdata[8:0] == 9'd0)
    else $error("nonzero hue on gray pixel");

endmodule

bind rgb_to_hsv_pixel_top rgbhsv_checker u_rgbhsv_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* tb/sv/rgb_to_hsv_pixel_top_test.sv */
// Self-checking testbench for the RGB to HSV pixel converter (rgb_to_hsv_pixel_top).
// Runs directed and random pixels through both stream ports and checks every result.
// Depends on rgbhsv_pkg and the converter RTL.
module rgb_to_hsv_pixel_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rgbhsv_pkg::*;

  typedef struct packed {
    logic [HueW-1:0]  hue;
    logic [ChanW-1:0] sat;
    logic [ChanW-1:0] val;
  } hsv_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // red[7:0], green[15:8], blue[23:16]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // hue_degrees[8:0], saturation_code[16:9],
                                    // value_code[24:17], zero[31:25]

  hsv_t hsv_expected[$];
  int   err_count = 0;
  bit   quiet_bus = 1'b0;           // no idling on either side while set

  rgb_to_hsv_pixel_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  function automatic hsv_t predict_hsv(input logic [ChanW-1:0] red, green, blue);
    hsv_t    res;
    int      vmax;
    int      vmin;
    int      delta;
    int      num;
    sector_e sect;
    vmax = int'(red);
    if (int'(green) > vmax) vmax = int'(green);
    if (int'(blue) > vmax) vmax = int'(blue);
    vmin = int'(red);
    if (int'(green) < vmin) vmin = int'(green);
    if (int'(blue) < vmin) vmin = int'(blue);
    delta = vmax - vmin;
    res = '0;
    res.val = ChanW'(vmax);
    if (delta != 0) begin
      res.sat = ChanW'((255 * delta) / vmax);
      // ties go to red first, then green
      if (int'(red) == vmax) sect = SECT_RED;
      else if (int'(green) == vmax) sect = SECT_GREEN;
      else sect = SECT_BLUE;
      case (sect)
        SECT_RED:   num = 60 * (int'(green) - int'(blue));
        SECT_GREEN: num = 120 * delta + 60 * (int'(blue) - int'(red));
        default:    num = 240 * delta + 60 * (int'(red) - int'(green));
      endcase
      if (num < 0) num += 360 * delta;
      if (num == 360 * delta) num = 0;
      res.hue = HueW'(num / delta);
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_count++;
  endtask

  // Output side backpressure
  always @(posedge clk_i) begin
    m_axis_tready <= quiet_bus || ($urandom_range(99) >= 7);
  end

  // Predict on every accepted input transaction
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      hsv_expected.push_back(predict_hsv(s_axis_tdata[7:0], s_axis_tdata[15:8],
                                         s_axis_tdata[23:16]));
    end
  end

  // Compare every accepted output transaction with the oldest prediction
  always @(posedge clk_i) begin
    hsv_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (hsv_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected result tdata=%h", m_axis_tdata));
      end else begin
        want = hsv_expected.pop_front();
        if (m_axis_tdata[8:0] !== want.hue)
          report_mismatch($sformatf("hue %0d, expected %0d",
                                    m_axis_tdata[8:0], want.hue));
        if (m_axis_tdata[16:9] !== want.sat)
          report_mismatch($sformatf("saturation %0d, expected %0d",
                                    m_axis_tdata[16:9], want.sat));
        if (m_axis_tdata[24:17] !== want.val)
          report_mismatch($sformatf("value %0d, expected %0d",
                                    m_axis_tdata[24:17], want.val));
        if (m_axis_tdata[31:25] !== '0)
          report_mismatch($sformatf("pad bits %h not zero", m_axis_tdata[31:25]));
      end
    end
  end

  // Called right after a rising edge; returns right after the accepting edge
  task automatic send_pixel(input logic [ChanW-1:0] red, green, blue);
    if (!quiet_bus && $urandom_range(99) < 7) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {blue, green, red};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic random_pixel();
    logic [ChanW-1:0] a, b, c;
    a = ChanW'($urandom);
    b = ChanW'($urandom);
    c = ChanW'($urandom);
    case ($urandom_range(9))
      5:       send_pixel(a, a, a);                               // gray
      6: begin                                                    // tie for max
        if (b > a) a = b;
        case ($urandom_range(2))
          0:       send_pixel(a, a, c & a);
          1:       send_pixel(a, c & a, a);
          default: send_pixel(c & a, a, a);
        endcase
      end
      7:       send_pixel(8'hff, ChanW'(b[1:0]), ChanW'(c[1:0])); // near primary
      8:       send_pixel(ChanW'(a[1:0]), ChanW'(b[1:0]),
                          ChanW'(c[1:0]));                        // tiny deltas
      9:       send_pixel(a, b[0] ? 8'hff : 8'h00, c);            // extremes
      default: send_pixel(a, b, c);
    endcase
  endtask

  task automatic test_directed();
    send_pixel(8'd0, 8'd0, 8'd0);         // black
    send_pixel(8'd255, 8'd255, 8'd255);   // white
    send_pixel(8'd128, 8'd128, 8'd128);   // mid gray
    send_pixel(8'd255, 8'd0, 8'd0);       // pure red
    send_pixel(8'd0, 8'd255, 8'd0);       // pure green
    send_pixel(8'd0, 8'd0, 8'd255);       // pure blue
    send_pixel(8'd255, 8'd255, 8'd0);     // red/green tie
    send_pixel(8'd0, 8'd255, 8'd255);     // green/blue tie
    send_pixel(8'd255, 8'd0, 8'd255);     // red/blue tie, negative hue wraps
    send_pixel(8'd255, 8'd0, 8'd1);       // hue just below 360
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd254, 8'd254);   // minimal saturation
    send_pixel(8'd1, 8'd1, 8'd0);
    send_pixel(8'd0, 8'd1, 8'd1);
    send_pixel(8'd254, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd254, 8'd255);
    send_pixel(8'd255, 8'd128, 8'd0);
    send_pixel(8'd200, 8'd100, 8'd150);
    send_pixel(8'd10, 8'd20, 8'd30);
    send_pixel(8'd255, 8'd1, 8'd0);
    send_pixel(8'd1, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd1, 8'd255);
    send_pixel(8'd0, 8'd255, 8'd1);
    send_pixel(8'd170, 8'd85, 8'd255);
  endtask

  task automatic test_random_pixels();
    for (int i = 0; i < 650; i++) random_pixel();
  endtask

  // full rate on both sides
  task automatic test_back_to_back();
    quiet_bus = 1'b1;
    for (int i = 0; i < 400; i++) random_pixel();
    quiet_bus = 1'b0;
  endtask

  task automatic wait_for_results();
    while (hsv_expected.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_pixels();
    test_back_to_back();
    test_random_pixels();
    s_axis_tvalid <= 1'b0;
    wait_for_results();
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* rgb_to_hsv_pixel_top.f */
rtl/core/rgbhsv_pkg.sv
rtl/core/rgb_to_hsv_pixel_top.sv
rtl/core/rgbhsv_checker.sv
tb/sv/rgb_to_hsv_pixel_top_test.sv
